/* design/lts_pkg.sv */
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants for the lottery thread scheduler: defaults, codes and
// generator constants.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned TidBitsDef = 16;
  localparam int unsigned DivW       = 32;

  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgAdd = 32'd1013904223;

  localparam logic [7:0] TicketsRst = 8'd10;

  localparam logic [1:0] StFree     = 2'd0;
  localparam logic [1:0] StRunnable = 2'd1;
  localparam logic [1:0] StRunning  = 2'd2;
  localparam logic [1:0] StSleeping = 2'd3;

  localparam logic [1:0] KindCreate = 2'd0;
  localparam logic [1:0] KindYield  = 2'd1;
  localparam logic [1:0] KindExit   = 2'd2;
  localparam logic [1:0] KindJoin   = 2'd3;

  localparam logic [2:0] StsSwitched  = 3'd0;
  localparam logic [2:0] StsCreated   = 3'd1;
  localparam logic [2:0] StsFull      = 3'd2;
  localparam logic [2:0] StsBadId     = 3'd3;
  localparam logic [2:0] StsNotAlive  = 3'd4;
  localparam logic [2:0] StsNoneRun   = 3'd5;
  localparam logic [2:0] StsAllExited = 3'd6;

endpackage

/* design/lottery_thread_scheduler_top.sv */
// ----------------------------------------------------------------------------
// lottery_thread_scheduler_top
// Thread slot table in one synchronous memory with a lottery pick per yield, join and exit.
// ----------------------------------------------------------------------------
// One item at a time; each slot visit reads the slot and then modifies it.
// Create: one sweep for a free slot. Yield: two sweeps plus two serial
// divisions. Exit adds a wake sweep before the yield, join adds a search
// sweep. The result is then handed over through the result register.
// Reset is asynchronous; per-slot valid bits give the reset contents, so
// there is no clearing pass.
module lottery_thread_scheduler_top
  import lts_pkg::*;
#(
  parameter int unsigned SLOTS    = SlotsDef,
  parameter int unsigned TID_BITS = TidBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] target_tid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  run_slot_o,
  output logic [15:0] run_tid_o,
  output logic [15:0] new_tid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = TID_BITS + 2;
  localparam logic [TID_BITS-1:0] TidMax = '1;

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhCreate = 4'd1;
  localparam logic [3:0] PhJoin   = 4'd2;
  localparam logic [3:0] PhSleep  = 4'd3;
  localparam logic [3:0] PhExit   = 4'd4;
  localparam logic [3:0] PhWake   = 4'd5;
  localparam logic [3:0] PhYa     = 4'd6;
  localparam logic [3:0] PhCount  = 4'd7;
  localparam logic [3:0] PhLcg    = 4'd8;
  localparam logic [3:0] PhDiv1   = 4'd9;
  localparam logic [3:0] PhDiv2   = 4'd10;
  localparam logic [3:0] PhPick   = 4'd11;
  localparam logic [3:0] PhFin    = 4'd12;

  logic [3:0]          ph_q, ph_d;
  logic                pend_q, pend_d;
  logic [SW-1:0]       idx_q, idx_d, cur_q, cur_d;
  logic [CW-1:0]       cnt_q, cnt_d, seen_q, seen_d, pick_q, pick_d;
  logic                found_q, found_d;
  logic [2:0]          sts_q, sts_d;
  logic [15:0]         made_q, made_d, tgt_q, tgt_d;
  logic [TID_BITS-1:0] next_q, next_d;
  logic [31:0]         lcg_q, lcg_d;
  logic [7:0]          tpt_q;

  logic                out_valid_q;
  logic [2:0]          o_sts_q;
  logic [3:0]          o_slot_q;
  logic [15:0]         o_tid_q, o_new_q;
  logic                out_load;

  // slot memory
  logic [EW-1:0]       mem_q [SLOTS];
  logic [SLOTS-1:0]    vld_q;
  logic [EW-1:0]       rd_q;
  logic                rvld_q, rzero_q;
  logic                mem_re, mem_we;
  logic [SW-1:0]       mem_addr;
  logic [1:0]          mem_wst;
  logic [TID_BITS-1:0] mem_wtid;
  logic [EW-1:0]       ent;
  logic [1:0]          ent_st;
  logic [TID_BITS-1:0] ent_tid;

  logic                div_start, div_busy;
  logic [DivW-1:0]     div_a, div_b, div_quo, div_rem;

  logic                last, inc;
  logic [CW-1:0]       cnt_n;
  logic [31:0]         cur32, tid32;

  assign last = (idx_q == SW'(SLOTS - 1));

  always_comb begin
    if (rvld_q) ent = rd_q;
    else        ent = {(rzero_q ? StRunning : StFree), {TID_BITS{1'b0}}};
  end
  assign ent_st  = ent[EW-1 -: 2];
  assign ent_tid = ent[TID_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= {mem_wst, mem_wtid};
    if (mem_re) rd_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      rzero_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[mem_addr] <= 1'b1;
      if (mem_re) begin
        rvld_q  <= vld_q[mem_addr];
        rzero_q <= (mem_addr == '0);
      end
    end
  end

  lts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (ph_q == PhDiv1) begin
      div_a = lcg_q;
      div_b = DivW'(tpt_q);
    end else begin
      div_a = div_quo;
      div_b = DivW'(cnt_q);
    end
  end

  assign in_ready_o = (ph_q == PhIdle);
  assign out_load   = (ph_q == PhFin) && pend_q && (!out_valid_q || out_ready_i);
  assign inc        = (ent_st == StRunnable) || (ent_st == StRunning);
  assign cnt_n      = cnt_q + CW'(inc);

  always_comb begin
    ph_d      = ph_q;
    pend_d    = pend_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    pick_d    = pick_q;
    found_d   = found_q;
    sts_d     = sts_q;
    made_d    = made_q;
    tgt_d     = tgt_q;
    next_d    = next_q;
    lcg_d     = lcg_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wst   = ent_st;
    mem_wtid  = ent_tid;
    mem_addr  = idx_q;
    div_start = 1'b0;

    unique case (ph_q) inside
      PhCreate, PhJoin, PhWake, PhCount, PhPick: mem_addr = idx_q;
      default:                                   mem_addr = cur_q;
    endcase

    unique case (ph_q) inside
      PhIdle: begin
        if (in_valid_i) begin
          made_d = '0;
          tgt_d  = target_tid_i;
          idx_d  = '0;
          pend_d = 1'b0;
          unique case (kind_i)
            KindCreate: ph_d = PhCreate;
            KindYield:  ph_d = PhYa;
            KindExit:   ph_d = PhExit;
            default: begin
              if (32'(target_tid_i) >= 32'(next_q)) begin
                sts_d = StsBadId;
                ph_d  = PhFin;
              end else begin
                ph_d = PhJoin;
              end
            end
          endcase
        end
      end
      PhLcg: begin
        lcg_d = 32'(lcg_q * LcgMul) + LcgAdd;
        ph_d  = PhDiv1;
      end
      PhDiv1, PhDiv2: begin
        if (!pend_q) begin
          div_start = 1'b1;
          pend_d    = 1'b1;
        end else if (!div_busy) begin
          pend_d = 1'b0;
          if (ph_q == PhDiv1) begin
            ph_d = PhDiv2;
          end else begin
            pick_d = div_rem[CW-1:0];
            seen_d = '0;
            idx_d  = '0;
            ph_d   = PhPick;
          end
        end
      end
      default: begin
        if (!pend_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
        end else if (ph_q != PhFin) begin
          pend_d = 1'b0;
          idx_d  = idx_q + SW'(1);
          case (ph_q)
            PhCreate: begin
              if (ent_st == StFree) begin
                mem_we   = 1'b1;
                mem_wst  = StRunnable;
                mem_wtid = next_q;
                made_d   = 16'(32'(next_q));
                if (next_q != TidMax) next_d = next_q + TID_BITS'(1);
                sts_d    = StsCreated;
                ph_d     = PhFin;
              end else if (last) begin
                sts_d = StsFull;
                ph_d  = PhFin;
              end
            end
            PhJoin: begin
              if (ent_st != StFree && 32'(ent_tid) == 32'(tgt_q)) begin
                ph_d = PhSleep;
              end else if (last) begin
                sts_d = StsNotAlive;
                ph_d  = PhFin;
              end
            end
            PhSleep: begin
              mem_we  = 1'b1;
              mem_wst = StSleeping;
              ph_d    = PhYa;
            end
            PhExit: begin
              mem_we  = 1'b1;
              mem_wst = StFree;
              found_d = 1'b0;
              idx_d   = '0;
              ph_d    = PhWake;
            end
            PhWake: begin
              if (ent_st == StSleeping) begin
                mem_we  = 1'b1;
                mem_wst = StRunnable;
              end
              if (ent_st != StFree) found_d = 1'b1;
              if (last) begin
                if (found_q || ent_st != StFree) begin
                  ph_d = PhYa;
                end else begin
                  sts_d = StsAllExited;
                  ph_d  = PhFin;
                end
              end
            end
            PhYa: begin
              if (ent_st == StRunning) begin
                mem_we  = 1'b1;
                mem_wst = StRunnable;
              end
              cnt_d = '0;
              idx_d = '0;
              ph_d  = PhCount;
            end
            PhCount: begin
              cnt_d = cnt_n;
              if (last) begin
                if (cnt_n == '0 || tpt_q == '0) begin
                  sts_d = StsNoneRun;
                  ph_d  = PhFin;
                end else begin
                  ph_d = PhLcg;
                end
              end
            end
            PhPick: begin
              if (ent_st == StRunnable && seen_q == pick_q) begin
                mem_we  = 1'b1;
                mem_wst = StRunning;
                cur_d   = idx_q;
                sts_d   = StsSwitched;
                ph_d    = PhFin;
              end else begin
                if (ent_st == StRunnable) seen_d = seen_q + CW'(1);
                if (last) begin
                  sts_d = StsNoneRun;
                  ph_d  = PhFin;
                end
              end
            end
            default: ph_d = PhIdle;
          endcase
        end else if (out_load) begin
          pend_d = 1'b0;
          ph_d   = PhIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PhIdle;
      pend_q  <= 1'b0;
      idx_q   <= '0;
      cur_q   <= '0;
      cnt_q   <= '0;
      seen_q  <= '0;
      pick_q  <= '0;
      found_q <= 1'b0;
      sts_q   <= StsSwitched;
      next_q  <= TID_BITS'(1);
      lcg_q   <= 32'd1;
    end else begin
      ph_q    <= ph_d;
      pend_q  <= pend_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      pick_q  <= pick_d;
      found_q <= found_d;
      sts_q   <= sts_d;
      next_q  <= next_d;
      lcg_q   <= lcg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    made_q <= made_d;
    tgt_q  <= tgt_d;
  end

  // result register
  assign cur32 = 32'(cur_q);
  assign tid32 = 32'(ent_tid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_sts_q  <= sts_q;
      o_slot_q <= cur32[3:0];
      o_tid_q  <= tid32[15:0];
      o_new_q  <= made_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_sts_q;
  assign run_slot_o  = o_slot_q;
  assign run_tid_o   = o_tid_q;
  assign new_tid_o   = o_new_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpt_q <= TicketsRst;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tpt_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(tpt_q);

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("divider busy while idle");

  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("slot memory read and write in one cycle");

  a_next_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q != '0)
    else $error("id counter wrapped");

endmodule

/* design/lts_div.sv */
// ----------------------------------------------------------------------------
// lts_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lts_div
  import lts_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            busy_o,
  output logic [DivW-1:0] quo_o,
  output logic [DivW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] rem_q, quo_q, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DivW:0]   shifted, diff;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DivW]) begin
        rem_q <= diff[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* tb/lottery_thread_scheduler_top_tb.sv */
// ----------------------------------------------------------------------------
// lottery_thread_scheduler_top_tb
// Drives create, yield, exit and join items through the scheduler and checks
// every result item against directed values or a model of the slot table,
// ticket sum and generator, across several ticket settings and idling phases.
// ----------------------------------------------------------------------------
module lottery_thread_scheduler_top_tb;
  import lts_pkg::*;

  localparam int NSLOTS = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] tid;
    logic [15:0] new_id;
  } sched_res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tid;
    logic        typed;
    sched_res_t  want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KindYield;
  logic [15:0] target_tid_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  run_slot_o;
  logic [15:0] run_tid_o;
  logic [15:0] new_tid_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lottery_thread_scheduler_top uut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic [1:0]  slot_st [NSLOTS];
  logic [15:0] slot_id [NSLOTS];
  logic [3:0]  cur_slot;
  logic [15:0] id_next;
  logic [31:0] lcg;
  logic [7:0]  tickets;

  sched_res_t  expected_q[$];
  int          fails = 0;
  int          tx_idle = 0;
  int          rx_stall = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic logic [2:0] lottery_pass();
    logic [31:0] sum, pick, seen;
    sum = 0;
    seen = 0;
    if (slot_st[cur_slot] == StRunning) slot_st[cur_slot] = StRunnable;
    for (int i = 0; i < NSLOTS; i++)
      if (slot_st[i] != StFree && slot_st[i] != StSleeping) sum += tickets;
    if (sum == 0 || tickets == 0) return StsNoneRun;
    lcg = lcg * LcgMul + LcgAdd;
    pick = (lcg % sum) / {24'd0, tickets};
    for (int i = 0; i < NSLOTS; i++) begin
      if (slot_st[i] == StRunnable) begin
        if (seen == pick) begin
          cur_slot = i[3:0];
          slot_st[i] = StRunning;
          return StsSwitched;
        end
        seen++;
      end
    end
    return StsNoneRun;
  endfunction

  function automatic sched_res_t schedule_item(logic [1:0] k, logic [15:0] t);
    sched_res_t r;
    int hit;
    r = '0;
    hit = -1;
    case (k)
      KindCreate: begin
        for (int i = NSLOTS - 1; i >= 0; i--) if (slot_st[i] == StFree) hit = i;
        if (hit < 0) begin
          r.status = StsFull;
        end else begin
          slot_id[hit] = id_next;
          slot_st[hit] = StRunnable;
          r.new_id = id_next;
          if (id_next != 16'hFFFF) id_next++;
          r.status = StsCreated;
        end
      end
      KindYield: r.status = lottery_pass();
      KindExit: begin
        slot_st[cur_slot] = StFree;
        for (int i = 0; i < NSLOTS; i++) if (slot_st[i] == StSleeping) slot_st[i] = StRunnable;
        for (int i = 0; i < NSLOTS; i++) if (slot_st[i] != StFree) hit = i;
        r.status = (hit >= 0) ? lottery_pass() : StsAllExited;
      end
      default: begin
        if (t >= id_next) begin
          r.status = StsBadId;
        end else begin
          for (int i = 0; i < NSLOTS; i++)
            if (slot_st[i] != StFree && slot_id[i] == t) hit = i;
          if (hit < 0) begin
            r.status = StsNotAlive;
          end else begin
            slot_st[cur_slot] = StSleeping;
            r.status = lottery_pass();
          end
        end
      end
    endcase
    r.slot = cur_slot;
    r.tid = slot_id[cur_slot];
    return r;
  endfunction

  task automatic offer(input logic [1:0] k, input logic [15:0] t, input bit typed,
                       input sched_res_t want);
    sched_res_t pred;
    if ($urandom_range(0, 99) < tx_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    target_tid_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    pred = schedule_item(k, t);
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_tickets(input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tickets = v;
  endtask

  task automatic random_item();
    logic [1:0]  k;
    logic [15:0] t;
    int          r, s;
    r = $urandom_range(0, 99);
    t = 16'($urandom_range(0, 65535));
    if (r < 3) begin
      // burst of exits, usually empties the table
      repeat (NSLOTS + 1) offer(KindExit, t, 1'b0, '0);
      return;
    end
    if (r < 33) k = KindCreate;
    else if (r < 68) k = KindYield;
    else if (r < 82) k = KindExit;
    else k = KindJoin;
    if (k == KindJoin && $urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, NSLOTS - 1);
      if (slot_st[s] != StFree) t = slot_id[s];
      else t = id_next - 16'($urandom_range(0, 1));
    end
    offer(k, t, 1'b0, '0);
  endtask

  // result side
  always @(posedge clk_i) begin
    sched_res_t w;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item status=%0d", status_o);
        fails++;
      end else begin
        w = expected_q.pop_front();
        if (status_o !== w.status) begin
          $error("status exp %0d got %0d", w.status, status_o);
          fails++;
        end
        if (run_slot_o !== w.slot) begin
          $error("run_slot exp %0d got %0d", w.slot, run_slot_o);
          fails++;
        end
        if (run_tid_o !== w.tid) begin
          $error("run_tid exp %0d got %0d", w.tid, run_tid_o);
          fails++;
        end
        if (new_tid_o !== w.new_id) begin
          $error("new_tid exp %0d got %0d", w.new_id, new_tid_o);
          fails++;
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t dir_tab [25];
    logic [7:0] tick_set [5];
    for (int i = 0; i < NSLOTS; i++) begin
      slot_st[i] = StFree;
      slot_id[i] = '0;
    end
    slot_st[0] = StRunning;
    cur_slot = '0;
    id_next = 16'd1;
    lcg = 32'd1;
    tickets = TicketsRst;

    dir_tab[0] = '{KindYield,  16'd0,     1'b1, '{StsSwitched, 4'd0, 16'd0, 16'd0}};
    dir_tab[1] = '{KindCreate, 16'd0,     1'b1, '{StsCreated,  4'd0, 16'd0, 16'd1}};
    dir_tab[2] = '{KindJoin,   16'hFFFF,  1'b1, '{StsBadId,    4'd0, 16'd0, 16'd0}};
    dir_tab[3] = '{KindJoin,   16'd1,     1'b1, '{StsSwitched, 4'd1, 16'd1, 16'd0}};
    dir_tab[4] = '{KindJoin,   16'd0,     1'b1, '{StsNoneRun,  4'd1, 16'd1, 16'd0}};
    dir_tab[5] = '{KindExit,   16'd0,     1'b1, '{StsSwitched, 4'd0, 16'd0, 16'd0}};
    for (int i = 6; i < 21; i++) dir_tab[i] = '{KindCreate, 16'd0, 1'b0, '0};
    dir_tab[21] = '{KindCreate, 16'd0,    1'b1, '{StsFull,     4'd0, 16'd0, 16'd0}};
    dir_tab[22] = '{KindJoin,   16'd1,    1'b1, '{StsNotAlive, 4'd0, 16'd0, 16'd0}};
    dir_tab[23] = '{KindYield,  16'd0,    1'b0, '0};
    dir_tab[24] = '{KindExit,   16'd0,    1'b0, '0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) offer(dir_tab[i].kind, dir_tab[i].tid, dir_tab[i].typed,
                               dir_tab[i].want);
    drain();

    tick_set = '{8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'd3, 8'd10};
    for (int ph = 0; ph < 5; ph++) begin
      write_tickets(tick_set[ph]);
      case (ph)
        1: begin tx_idle = 49; rx_stall = 0; end
        2: begin tx_idle = 0; rx_stall = 49; end
        3: begin tx_idle = 33; rx_stall = 33; end
        default: begin tx_idle = 0; rx_stall = 0; end
      endcase
      if (ph == 4) hold_req = ~hold_req;
      for (int n = 0; n < 120; n++) begin
        random_item();
        if (n == 60) drain();
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d result items never arrived", expected_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
design/lts_pkg.sv
design/lts_div.sv
design/lottery_thread_scheduler_top.sv
tb/lottery_thread_scheduler_top_tb.sv
